// ===== src/prs_pkg.sv =====
// Shared types and fixed field widths of the priority request stack.
// Holds the item structs, the operation and state codes and the check result.
// Depends on nothing; every other file of the block imports it.
package prs_pkg;

    localparam int REQ_ID_W  = 8;
    localparam int REQ_LVL_W = 2;
    localparam int BUF_W     = 2;

    typedef enum logic [1:0] {
        OP_QUEUE   = 2'd0,
        OP_UNQUEUE = 2'd1,
        OP_UPDATE  = 2'd2,
        OP_SELECT  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT
    } t_state;

    // stored readiness flags, has_file in bit 0
    typedef struct packed {
        logic [BUF_W-1:0] buffers_filled;
        logic             wants_data;
        logic             in_progress;
        logic             has_file;
    } t_flags;

    typedef struct packed {
        t_op                  operation;
        logic [REQ_ID_W-1:0]  request_id;
        logic [REQ_LVL_W-1:0] priority_level;
        logic                 has_file;
        logic                 in_progress;
        logic                 wants_data;
        logic [BUF_W-1:0]     buffers_filled;
    } t_req;

    typedef struct packed {
        logic                 success;
        logic [REQ_ID_W-1:0]  selected_id;
        logic [REQ_LVL_W-1:0] selected_level;
    } t_res;

    // outcome of checking one stored entry
    typedef struct packed {
        logic id_hit;
        logic sel_hit;
    } t_chk;

endpackage

// ===== src/prs_entry_check.sv =====
// Match and eligibility check of one entry read from the entry memory.
// Depends on prs_pkg for the flag and check result types.
module prs_entry_check
    import prs_pkg::*;
#(
    parameter int ID_BITS = 8
) (
    input  logic [ID_BITS-1:0] i_key,
    input  logic [ID_BITS-1:0] i_id,
    input  t_flags             i_flags,
    input  logic               i_is_top,
    output t_chk               o_chk
);

    logic ready;

    assign ready = i_flags.has_file && i_flags.in_progress && i_flags.wants_data;

    always_comb begin
        o_chk.id_hit = (i_id == i_key);
        // top level takes only entries with no filled buffers, others fewer than two
        if (i_is_top) begin
            o_chk.sel_hit = ready && (i_flags.buffers_filled == '0);
        end else begin
            o_chk.sel_hit = ready && !i_flags.buffers_filled[1];
        end
    end

endmodule

// ===== src/priority_request_stack_core.sv =====
// Top level of the priority request stack: per-level entry lists in one memory.
// Depends on prs_pkg and prs_entry_check.
//
//  channel   ports                     direction  handshake
//  request   start, busy, i_req        in         taken when start high and busy low
//  result    o_done, o_res             out        o_done high one cycle, no backpressure
//
// Queue gives its result in the cycle after it is taken and never raises busy.
// Unqueue, update and select walk the entry memory through its single registered read
// port, one entry per cycle while a level has entries left; unqueue then moves each
// younger entry of that level down one slot to close the gap.
// Reset clears the control state and per-level counts, not the memory; the memory needs no clearing pass.
// The receiver cannot stall: each result is valid on o_res in the cycle o_done is high.
module priority_request_stack_core
    import prs_pkg::*;
#(
    parameter int LEVELS          = 4,
    parameter int DEPTH_PER_LEVEL = 4,
    parameter int ID_BITS         = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_req i_req,
    output logic busy,
    output logic o_done,
    output t_res o_res
);

    localparam int SLOTS     = LEVELS * DEPTH_PER_LEVEL;
    localparam int ADDR_W    = $clog2(SLOTS);
    localparam int LVL_W     = $clog2(LEVELS);
    localparam int CNT_W     = $clog2(DEPTH_PER_LEVEL + 1);
    localparam int IDX_W     = (DEPTH_PER_LEVEL > 1) ? $clog2(DEPTH_PER_LEVEL) : 1;
    localparam int ID_EXT_W  = (ID_BITS > REQ_ID_W) ? ID_BITS : REQ_ID_W;
    localparam int LVL_EXT_W = (LVL_W > REQ_LVL_W) ? LVL_W : REQ_LVL_W;
    localparam logic [LVL_W-1:0] TOP_LVL  = LVL_W'(LEVELS - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH_PER_LEVEL);

    typedef struct packed {
        logic [ID_BITS-1:0] id;
        t_flags             flags;
    } t_entry;

    function automatic logic [ADDR_W-1:0] slot_addr(input logic [LVL_W-1:0] lvl,
                                                    input logic [IDX_W-1:0] idx);
        return ADDR_W'(lvl) * ADDR_W'(DEPTH_PER_LEVEL) + ADDR_W'(idx);
    endfunction

    // entry memory: one write port, one registered read port
    t_entry r_mem [SLOTS];
    t_entry r_rd_data;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_wa;
    t_entry            mem_wd;
    logic [ADDR_W-1:0] rd_addr;

    // control state
    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count [LEVELS];
    logic [CNT_W-1:0]  n_count [LEVELS];
    logic              r_iss_on, n_iss_on;
    logic              r_chk_v, n_chk_v;
    logic              r_wr_v, n_wr_v;
    logic              r_done, n_done;

    // item and walk registers
    t_op               r_op, n_op;
    logic [ID_BITS-1:0] r_key, n_key;
    t_flags            r_flags, n_flags;
    logic              r_down, n_down;
    logic [LVL_W-1:0]  r_lvl, n_lvl;
    logic [CNT_W-1:0]  r_left, n_left;
    logic [LVL_W-1:0]  r_chk_lvl, n_chk_lvl;
    logic [IDX_W-1:0]  r_chk_idx, n_chk_idx;
    logic              r_found, n_found;
    logic [LVL_W-1:0]  r_sh_lvl, n_sh_lvl;
    logic [CNT_W-1:0]  r_sh_src, n_sh_src;
    logic [CNT_W-1:0]  r_sh_n, n_sh_n;
    logic [IDX_W-1:0]  r_wr_idx, n_wr_idx;
    t_res              r_res, n_res;

    // input decode
    logic                 acc;
    logic [ID_BITS-1:0]   in_id;
    logic [LVL_EXT_W-1:0] in_lvl_ext;
    logic [LVL_W-1:0]     in_lvl;
    logic                 lvl_ok;
    t_flags               in_flags;
    logic [LVL_W-1:0]     start_lvl;

    // walk decode
    logic [CNT_W-1:0] cur_cnt;
    logic [IDX_W-1:0] iss_idx;
    logic [LVL_W-1:0] nxt_lvl;
    logic             last_lvl;
    t_chk             chk;
    logic             sel_stop, unq_stop, upd_hit, scan_dry, shift_done;
    logic             cnt_over;

    assign busy   = (r_state != ST_IDLE);
    assign acc    = start && !busy;
    assign o_done = r_done;
    assign o_res  = r_res;

    assign in_id      = ID_BITS'(ID_EXT_W'(i_req.request_id));
    assign in_lvl_ext = LVL_EXT_W'(i_req.priority_level);
    assign in_lvl     = in_lvl_ext[LVL_W-1:0];
    // one spare bit so a full power-of-two level count still compares
    assign lvl_ok     = ({1'b0, in_lvl_ext} < (LVL_EXT_W + 1)'(LEVELS));
    assign start_lvl  = (i_req.operation == OP_SELECT) ? TOP_LVL : '0;

    always_comb begin
        in_flags.has_file       = i_req.has_file;
        in_flags.in_progress    = i_req.in_progress;
        in_flags.wants_data     = i_req.wants_data;
        in_flags.buffers_filled = i_req.buffers_filled;
    end

    // select walks newest first from the top; the others walk oldest first from level 0
    assign cur_cnt  = r_count[r_lvl];
    assign iss_idx  = r_down ? IDX_W'(r_left - CNT_W'(1)) : IDX_W'(cur_cnt - r_left);
    assign nxt_lvl  = r_down ? (r_lvl - LVL_W'(1)) : (r_lvl + LVL_W'(1));
    assign last_lvl = r_down ? (r_lvl == '0) : (r_lvl == TOP_LVL);

    prs_entry_check #(
        .ID_BITS(ID_BITS)
    ) u_check (
        .i_key   (r_key),
        .i_id    (r_rd_data.id),
        .i_flags (r_rd_data.flags),
        .i_is_top(r_chk_lvl == TOP_LVL),
        .o_chk   (chk)
    );

    assign sel_stop   = r_chk_v && (r_op == OP_SELECT) && chk.sel_hit;
    assign unq_stop   = r_chk_v && (r_op == OP_UNQUEUE) && chk.id_hit;
    assign upd_hit    = r_chk_v && (r_op == OP_UPDATE) && chk.id_hit;
    assign scan_dry   = !r_iss_on && !r_chk_v;
    assign shift_done = (r_sh_src >= r_sh_n) && !r_wr_v;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (acc && (i_req.operation != OP_QUEUE)) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (unq_stop) begin
                    n_state = ST_SHIFT;
                end else if (sel_stop || scan_dry) begin
                    n_state = ST_IDLE;
                end
            end
            ST_SHIFT: begin
                if (shift_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // datapath, memory ports and results
    always_comb begin
        n_count   = r_count;
        n_iss_on  = r_iss_on;
        n_chk_v   = 1'b0;
        n_wr_v    = 1'b0;
        n_done    = 1'b0;
        n_op      = r_op;
        n_key     = r_key;
        n_flags   = r_flags;
        n_down    = r_down;
        n_lvl     = r_lvl;
        n_left    = r_left;
        n_chk_lvl = r_chk_lvl;
        n_chk_idx = r_chk_idx;
        n_found   = r_found;
        n_sh_lvl  = r_sh_lvl;
        n_sh_src  = r_sh_src;
        n_sh_n    = r_sh_n;
        n_wr_idx  = r_wr_idx;
        n_res     = r_res;
        mem_we    = 1'b0;
        mem_wa    = '0;
        mem_wd    = r_rd_data;
        rd_addr   = '0;

        case (r_state)
            ST_IDLE: begin
                if (acc) begin
                    n_op    = i_req.operation;
                    n_key   = in_id;
                    n_flags = in_flags;
                    if (i_req.operation == OP_QUEUE) begin
                        // append at the level tail, or report a full or absent level
                        n_done = 1'b1;
                        n_res  = '0;
                        if (lvl_ok && (r_count[in_lvl] < FULL_CNT)) begin
                            mem_we            = 1'b1;
                            mem_wa            = slot_addr(in_lvl, IDX_W'(r_count[in_lvl]));
                            mem_wd.id         = in_id;
                            mem_wd.flags      = in_flags;
                            n_count[in_lvl]   = r_count[in_lvl] + CNT_W'(1);
                            n_res.success     = 1'b1;
                        end
                    end else begin
                        n_down   = (i_req.operation == OP_SELECT);
                        n_lvl    = start_lvl;
                        n_left   = r_count[start_lvl];
                        n_iss_on = 1'b1;
                        n_found  = 1'b0;
                    end
                end
            end
            ST_SCAN: begin
                // issue one read per cycle; step to the next level when this one runs out
                if (r_iss_on) begin
                    if (r_left != '0) begin
                        rd_addr   = slot_addr(r_lvl, iss_idx);
                        n_left    = r_left - CNT_W'(1);
                        n_chk_v   = 1'b1;
                        n_chk_lvl = r_lvl;
                        n_chk_idx = iss_idx;
                    end else if (last_lvl) begin
                        n_iss_on = 1'b0;
                    end else begin
                        n_lvl  = nxt_lvl;
                        n_left = r_count[nxt_lvl];
                    end
                end
                // write back new flags for every matching id
                if (upd_hit) begin
                    mem_we       = 1'b1;
                    mem_wa       = slot_addr(r_chk_lvl, r_chk_idx);
                    mem_wd.id    = r_rd_data.id;
                    mem_wd.flags = r_flags;
                    n_found      = 1'b1;
                end
                if (sel_stop) begin
                    // drop the read still in flight
                    n_iss_on             = 1'b0;
                    n_chk_v              = 1'b0;
                    n_done               = 1'b1;
                    n_res.success        = 1'b1;
                    n_res.selected_id    = REQ_ID_W'(ID_EXT_W'(r_rd_data.id));
                    n_res.selected_level = REQ_LVL_W'(LVL_EXT_W'(r_chk_lvl));
                end else if (unq_stop) begin
                    // shrink the level now, then move the younger entries down one slot
                    n_iss_on           = 1'b0;
                    n_chk_v            = 1'b0;
                    n_count[r_chk_lvl] = r_count[r_chk_lvl] - CNT_W'(1);
                    n_sh_lvl           = r_chk_lvl;
                    n_sh_src           = CNT_W'(r_chk_idx) + CNT_W'(1);
                    n_sh_n             = r_count[r_chk_lvl];
                end else if (scan_dry) begin
                    n_done        = 1'b1;
                    n_res         = '0;
                    n_res.success = r_found;
                end
            end
            ST_SHIFT: begin
                // read slot k+1 now, write it to slot k on the next cycle
                if (r_sh_src < r_sh_n) begin
                    rd_addr  = slot_addr(r_sh_lvl, IDX_W'(r_sh_src));
                    n_sh_src = r_sh_src + CNT_W'(1);
                    n_wr_v   = 1'b1;
                    n_wr_idx = IDX_W'(r_sh_src - CNT_W'(1));
                end
                if (r_wr_v) begin
                    mem_we = 1'b1;
                    mem_wa = slot_addr(r_sh_lvl, r_wr_idx);
                    mem_wd = r_rd_data;
                end
                if (shift_done) begin
                    n_done        = 1'b1;
                    n_res         = '0;
                    n_res.success = 1'b1;
                end
            end
            default: begin
                n_iss_on = 1'b0;
            end
        endcase
    end

    // entry memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[rd_addr];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_iss_on <= 1'b0;
            r_chk_v  <= 1'b0;
            r_wr_v   <= 1'b0;
            r_done   <= 1'b0;
            for (int l = 0; l < LEVELS; l++) begin
                r_count[l] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_iss_on <= n_iss_on;
            r_chk_v  <= n_chk_v;
            r_wr_v   <= n_wr_v;
            r_done   <= n_done;
            r_count  <= n_count;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_key     <= n_key;
        r_flags   <= n_flags;
        r_down    <= n_down;
        r_lvl     <= n_lvl;
        r_left    <= n_left;
        r_chk_lvl <= n_chk_lvl;
        r_chk_idx <= n_chk_idx;
        r_found   <= n_found;
        r_sh_lvl  <= n_sh_lvl;
        r_sh_src  <= n_sh_src;
        r_sh_n    <= n_sh_n;
        r_wr_idx  <= n_wr_idx;
        r_res     <= n_res;
    end

    always_comb begin
        cnt_over = 1'b0;
        for (int l = 0; l < LEVELS; l++) begin
            cnt_over = cnt_over || (r_count[l] > FULL_CNT);
        end
    end

    // a result always comes with the block ready for the next item
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    a_queue_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && (i_req.operation == OP_QUEUE)) |=> o_done)
        else $error("queue result not one cycle after accept");

    a_plain_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (r_op != OP_SELECT)) |->
            ((o_res.selected_id == '0) && (o_res.selected_level == '0)))
        else $error("selection fields set on a non-select result");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !cnt_over)
        else $error("level count above depth");

    a_shift_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_SHIFT) && r_wr_v) |-> (CNT_W'(r_wr_idx) < r_sh_n))
        else $error("gap close writes past the level tail");

endmodule

// ===== dv/tb_priority_request_stack_core.sv =====
`timescale 1ns / 100ps
// Self-checking bench for priority_request_stack_core: a directed table, then random items.
// Depends on prs_pkg for the item structs and operation codes.
module tb_priority_request_stack_core;
    import prs_pkg::*;

    localparam int LEVELS          = 4;
    localparam int DEPTH_PER_LEVEL = 4;
    localparam int ID_BITS         = 8;
    localparam int SLOTS           = LEVELS * DEPTH_PER_LEVEL;
    localparam int ID_MASK         = (1 << ID_BITS) - 1;
    localparam int RANDOM_ITEMS    = 700;
    // A select walks at most 16 entries; sender gaps are short.
    localparam int QUIET_LIMIT     = 5000;
    localparam int DRAIN_CYCLES    = 40;

    // One line of the directed table; a fixed row carries its own expected result.
    typedef struct {
        t_req req;
        bit   fixed;
        t_res res;
    } t_stim_row;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_req i_req   = '0;
    logic busy;
    logic o_done;
    t_res o_res;

    // Side channel that rides along with the item being offered.
    bit   row_fixed = 1'b0;
    t_res row_res   = '0;

    // Shadow copy of the stack, kept in step with every accepted item.
    int          lvl_count [LEVELS];
    logic [7:0]  slot_id   [SLOTS];
    t_flags      slot_flags[SLOTS];

    t_res        pending_results[$];
    t_stim_row   directed_rows[$];
    t_res        want_res;
    int          err_count    = 0;
    int unsigned quiet_cycles = 0;
    int          idle_pct     = 0;

    priority_request_stack_core #(
        .LEVELS         (LEVELS),
        .DEPTH_PER_LEVEL(DEPTH_PER_LEVEL),
        .ID_BITS        (ID_BITS)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .i_req  (i_req),
        .busy   (busy),
        .o_done (o_done),
        .o_res  (o_res)
    );

    always #10 i_clk = ~i_clk;

    task automatic note_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        err_count++;
    endtask

    // Apply one item to the shadow stack and return the result it must produce.
    function automatic t_res advance_stack(input t_req r);
        t_res       res;
        t_flags     fl;
        t_flags     sf;
        logic [7:0] id;
        int         lvl;
        int         base;
        int         p;
        int         i;
        int         k;
        bit         found;
        bit         ok;
        res   = '0;
        found = 1'b0;
        id    = REQ_ID_W'(r.request_id & ID_MASK);
        lvl   = int'(r.priority_level);
        fl    = {r.buffers_filled, r.wants_data, r.in_progress, r.has_file};
        case (r.operation)
            OP_QUEUE: begin
                if (lvl < LEVELS && lvl_count[lvl] < DEPTH_PER_LEVEL) begin
                    slot_id[lvl * DEPTH_PER_LEVEL + lvl_count[lvl]]    = id;
                    slot_flags[lvl * DEPTH_PER_LEVEL + lvl_count[lvl]] = fl;
                    lvl_count[lvl]++;
                    res.success = 1'b1;
                end
            end
            OP_UNQUEUE: begin
                // Remove the first match, lowest level and oldest entry first; close the gap.
                for (p = 0; p < LEVELS && !found; p++) begin
                    base = p * DEPTH_PER_LEVEL;
                    for (i = 0; i < lvl_count[p] && !found; i++) begin
                        if (slot_id[base + i] == id) begin
                            for (k = i; k + 1 < lvl_count[p]; k++) begin
                                slot_id[base + k]    = slot_id[base + k + 1];
                                slot_flags[base + k] = slot_flags[base + k + 1];
                            end
                            lvl_count[p]--;
                            found = 1'b1;
                        end
                    end
                end
                res.success = found;
            end
            OP_UPDATE: begin
                // Rewrite every matching entry.
                for (p = 0; p < LEVELS; p++) begin
                    for (i = 0; i < lvl_count[p]; i++) begin
                        if (slot_id[p * DEPTH_PER_LEVEL + i] == id) begin
                            slot_flags[p * DEPTH_PER_LEVEL + i] = fl;
                            found = 1'b1;
                        end
                    end
                end
                res.success = found;
            end
            default: begin
                // Scan top level down, newest first; top level demands empty buffers.
                for (p = LEVELS - 1; p >= 0 && !found; p--) begin
                    for (i = lvl_count[p] - 1; i >= 0 && !found; i--) begin
                        sf = slot_flags[p * DEPTH_PER_LEVEL + i];
                        ok = sf.has_file && sf.in_progress && sf.wants_data;
                        if (p == LEVELS - 1)
                            ok = ok && (sf.buffers_filled == 2'd0);
                        else
                            ok = ok && (sf.buffers_filled < 2'd2);
                        if (ok) begin
                            res.success        = 1'b1;
                            res.selected_id    = slot_id[p * DEPTH_PER_LEVEL + i];
                            res.selected_level = REQ_LVL_W'(p);
                            found              = 1'b1;
                        end
                    end
                end
            end
        endcase
        return res;
    endfunction

    // Build one table row; rdy packs {wants_data, in_progress, has_file}.
    function automatic t_stim_row stim_row(input t_op op, input logic [7:0] id,
                                           input logic [1:0] lvl, input logic [2:0] rdy,
                                           input logic [1:0] bufs, input bit fixed,
                                           input t_res res);
        t_stim_row row;
        row.req.operation      = op;
        row.req.request_id     = id;
        row.req.priority_level = lvl;
        row.req.wants_data     = rdy[2];
        row.req.in_progress    = rdy[1];
        row.req.has_file       = rdy[0];
        row.req.buffers_filled = bufs;
        row.fixed              = fixed;
        row.res                = res;
        return row;
    endfunction

    // Mostly well-formed traffic: ids that are stored, ready flags, room in the levels.
    function automatic t_req random_request();
        t_req       r;
        logic [7:0] stored[$];
        int         roll;
        int         p;
        int         i;
        int         q_pct;
        for (p = 0; p < LEVELS; p++)
            for (i = 0; i < lvl_count[p]; i++)
                stored.push_back(slot_id[p * DEPTH_PER_LEVEL + i]);
        // Throttle queueing when the stack is nearly full so removals keep up.
        q_pct = (stored.size() >= 12) ? 15 : 40;
        roll  = $urandom_range(0, 99);
        if (roll < q_pct)
            r.operation = OP_QUEUE;
        else if (roll < q_pct + 20)
            r.operation = OP_UNQUEUE;
        else if (roll < q_pct + 38)
            r.operation = OP_UPDATE;
        else
            r.operation = OP_SELECT;
        r.request_id = 8'($urandom_range(0, 255));
        if (r.operation == OP_QUEUE) begin
            // Draw from a small pool now and then to build duplicates.
            if ($urandom_range(0, 99) < 35)
                r.request_id = 8'($urandom_range(0, 7));
        end else if (stored.size() > 0 && $urandom_range(0, 99) < 75) begin
            r.request_id = stored[$urandom_range(0, stored.size() - 1)];
        end
        r.priority_level = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 99) < 60)
            {r.wants_data, r.in_progress, r.has_file} = 3'b111;
        else
            {r.wants_data, r.in_progress, r.has_file} = 3'($urandom_range(0, 7));
        r.buffers_filled = 2'($urandom_range(0, 3));
        return r;
    endfunction

    // Offer one item: idle at random first, then hold start until the block takes it.
    task automatic send_item(input t_req r, input bit fixed, input t_res res);
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start     <= 1'b1;
        i_req     <= r;
        row_fixed <= fixed;
        row_res   <= res;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
    endtask

    // Check results before taking the new item: a result never belongs to this edge's item.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done === 1'b1) begin
                if (pending_results.size() == 0) begin
                    note_mismatch("result with nothing pending");
                end else begin
                    want_res = pending_results.pop_front();
                    if (o_res.success !== want_res.success)
                        note_mismatch($sformatf("success got %b want %b",
                                                o_res.success, want_res.success));
                    if (o_res.selected_id !== want_res.selected_id)
                        note_mismatch($sformatf("selected_id got %h want %h",
                                                o_res.selected_id, want_res.selected_id));
                    if (o_res.selected_level !== want_res.selected_level)
                        note_mismatch($sformatf("selected_level got %0d want %0d",
                                                o_res.selected_level,
                                                want_res.selected_level));
                end
            end
            if (start && busy === 1'b0) begin
                want_res = advance_stack(i_req);
                pending_results.push_back(row_fixed ? row_res : want_res);
            end
        end
    end

    // Drop the run if nothing moves on either side for too long.
    initial begin
        forever begin
            @(posedge i_clk);
            if ((start && busy === 1'b0) || o_done === 1'b1) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT) begin
                    $display("watchdog: no traffic for %0d cycles", QUIET_LIMIT);
                    $display("priority_request_stack_core verification failed");
                    $finish;
                end
            end
        end
    end

    initial begin
        int n;
        for (n = 0; n < LEVELS; n++)
            lvl_count[n] = 0;

        // Directed table: empty stack, extremes, full level, duplicates, buffer code three.
        directed_rows.push_back(stim_row(OP_SELECT,  8'h00, 2'd0, 3'b111, 2'd0, 1'b1, '0));
        directed_rows.push_back(stim_row(OP_UNQUEUE, 8'h05, 2'd0, 3'b000, 2'd0, 1'b1, '0));
        directed_rows.push_back(stim_row(OP_UPDATE,  8'h05, 2'd2, 3'b111, 2'd0, 1'b1, '0));
        directed_rows.push_back(stim_row(OP_QUEUE,   8'h00, 2'd0, 3'b111, 2'd0, 1'b1,
                                         t_res'{1'b1, 8'h00, 2'd0}));
        directed_rows.push_back(stim_row(OP_QUEUE,   8'hFF, 2'd3, 3'b111, 2'd0, 1'b1,
                                         t_res'{1'b1, 8'h00, 2'd0}));
        directed_rows.push_back(stim_row(OP_SELECT,  8'h00, 2'd0, 3'b000, 2'd0, 1'b1,
                                         t_res'{1'b1, 8'hFF, 2'd3}));
        directed_rows.push_back(stim_row(OP_QUEUE,   8'hAA, 2'd3, 3'b111, 2'd1, 1'b1,
                                         t_res'{1'b1, 8'h00, 2'd0}));
        directed_rows.push_back(stim_row(OP_SELECT,  8'h00, 2'd0, 3'b000, 2'd0, 1'b0, '0));
        directed_rows.push_back(stim_row(OP_QUEUE,   8'h55, 2'd3, 3'b111, 2'd0, 1'b0, '0));
        directed_rows.push_back(stim_row(OP_QUEUE,   8'h12, 2'd3, 3'b000, 2'd0, 1'b0, '0));
        // Level three now holds four entries.
        directed_rows.push_back(stim_row(OP_QUEUE,   8'h34, 2'd3, 3'b111, 2'd0, 1'b1, '0));
        directed_rows.push_back(stim_row(OP_SELECT,  8'h00, 2'd0, 3'b000, 2'd0, 1'b0, '0));
        directed_rows.push_back(stim_row(OP_UPDATE,  8'h55, 2'd0, 3'b111, 2'd3, 1'b0, '0));
        directed_rows.push_back(stim_row(OP_QUEUE,   8'h77, 2'd2, 3'b111, 2'd1, 1'b0, '0));
        directed_rows.push_back(stim_row(OP_SELECT,  8'h00, 2'd0, 3'b000, 2'd0, 1'b0, '0));
        directed_rows.push_back(stim_row(OP_UPDATE,  8'hFF, 2'd1, 3'b000, 2'd0, 1'b0, '0));
        directed_rows.push_back(stim_row(OP_SELECT,  8'h00, 2'd0, 3'b000, 2'd0, 1'b0, '0));
        directed_rows.push_back(stim_row(OP_QUEUE,   8'h77, 2'd1, 3'b111, 2'd2, 1'b0, '0));
        directed_rows.push_back(stim_row(OP_UPDATE,  8'h77, 2'd0, 3'b111, 2'd0, 1'b0, '0));
        directed_rows.push_back(stim_row(OP_UNQUEUE, 8'h77, 2'd0, 3'b000, 2'd0, 1'b0, '0));
        directed_rows.push_back(stim_row(OP_UNQUEUE, 8'hAA, 2'd0, 3'b000, 2'd0, 1'b0, '0));
        directed_rows.push_back(stim_row(OP_QUEUE,   8'h01, 2'd1, 3'b011, 2'd0, 1'b0, '0));
        directed_rows.push_back(stim_row(OP_QUEUE,   8'h02, 2'd1, 3'b101, 2'd0, 1'b0, '0));
        directed_rows.push_back(stim_row(OP_QUEUE,   8'h03, 2'd1, 3'b110, 2'd0, 1'b0, '0));
        directed_rows.push_back(stim_row(OP_SELECT,  8'h00, 2'd0, 3'b000, 2'd0, 1'b0, '0));

        // Hold reset low from the start, then release it once for the whole run.
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        idle_pct = 8;
        foreach (directed_rows[n])
            send_item(directed_rows[n].req, directed_rows[n].fixed, directed_rows[n].res);

        // Random part in three phases: light sender gaps, heavy gaps, back to back.
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 3)
                idle_pct = 84;
            else if (n == 2 * RANDOM_ITEMS / 3)
                idle_pct = 0;
            send_item(random_request(), 1'b0, '0);
        end
        start     <= 1'b0;
        row_fixed <= 1'b0;

        // Drain outstanding results, then give stray ones time to show up.
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_count == 0 && pending_results.size() == 0)
            $display("priority_request_stack_core verification clean");
        else
            $display("priority_request_stack_core verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/prs_pkg.sv
src/prs_entry_check.sv
src/priority_request_stack_core.sv
dv/tb_priority_request_stack_core.sv
